[sv/sorted_unique_key_table_unit_macros.svh]
// Assertion macros for the sorted key table. All checks run on aclk and are
// held off while aresetn is low.
`ifndef SORTED_UNIQUE_KEY_TABLE_UNIT_MACROS_SVH
`define SORTED_UNIQUE_KEY_TABLE_UNIT_MACROS_SVH

// A condition that must hold at every clock edge.
`define SUKT_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define SUKT_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define SUKT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/sukt_pkg.sv]
`timescale 1ns / 1ps

package sukt_pkg;

    // Field widths of a request and a result.
    localparam int OP_W        = 2;
    localparam int PC_W        = 20;
    localparam int NUM_W       = 47;
    localparam int HANDLE_IN_W = 16;
    localparam int STATUS_W    = 2;
    localparam int POS_OUT_W   = 8;
    localparam int COUNT_OUT_W = 9;
    localparam int S_TDATA_W   = 88;
    localparam int M_TDATA_W   = 56;

    // Cells per reduction group.
    localparam int GROUP_SIZE = 16;

    // Request opcodes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef logic [PC_W-1:0]  postal_t;
    typedef logic [NUM_W-1:0] number_t;

    // Update command broadcast to the cell row.
    typedef struct packed {
        logic ins_en;
        logic del_en;
    } cell_ctrl_t;

endpackage

[sv/sukt_cell.sv]
`timescale 1ns / 1ps

module sukt_cell #(
    parameter int CELL_IDX = 0,
    parameter int PW       = 8,
    parameter int CW       = 9,
    parameter int HW       = 16
) (
    input  logic                 aclk,
    input  logic                 cmp_en,
    input  sukt_pkg::cell_ctrl_t ctrl,
    input  logic [PW-1:0]        upd_pos,
    input  logic [CW-1:0]        count,
    input  sukt_pkg::postal_t    key_pc,
    input  sukt_pkg::number_t    key_num,
    input  logic [HW-1:0]        key_hd,
    input  sukt_pkg::postal_t    left_pc,
    input  sukt_pkg::number_t    left_num,
    input  logic [HW-1:0]        left_hd,
    input  sukt_pkg::postal_t    right_pc,
    input  sukt_pkg::number_t    right_num,
    input  logic [HW-1:0]        right_hd,
    output sukt_pkg::postal_t    pc,
    output sukt_pkg::number_t    num,
    output logic [HW-1:0]        hd,
    output logic                 match,
    output logic                 less
);

    localparam logic [PW-1:0] IDX_POS = PW'(CELL_IDX);
    localparam logic [CW-1:0] IDX_CNT = CW'(CELL_IDX);

    sukt_pkg::postal_t pc_reg;
    sukt_pkg::number_t num_reg;
    logic [HW-1:0]     hd_reg;
    logic              match_reg;
    logic              less_reg;
    logic              valid;

    // Entries below the fill count are live; the rest never report a match or less.
    assign valid = (IDX_CNT < count);

    // Compare the live entry with the key of the request.
    always_ff @(posedge aclk) begin
        if (cmp_en) begin
            match_reg <= valid && (num_reg == key_num);
            less_reg  <= valid && ((pc_reg < key_pc) ||
                                   ((pc_reg == key_pc) && (num_reg < key_num)));
        end
    end

    // Insert moves entries up from the left neighbor, delete pulls from the right.
    always_ff @(posedge aclk) begin
        if (ctrl.ins_en) begin
            if (IDX_POS > upd_pos) begin
                pc_reg  <= left_pc;
                num_reg <= left_num;
                hd_reg  <= left_hd;
            end else if (IDX_POS == upd_pos) begin
                pc_reg  <= key_pc;
                num_reg <= key_num;
                hd_reg  <= key_hd;
            end
        end else if (ctrl.del_en && (IDX_POS >= upd_pos)) begin
            pc_reg  <= right_pc;
            num_reg <= right_num;
            hd_reg  <= right_hd;
        end
    end

    assign pc    = pc_reg;
    assign num   = num_reg;
    assign hd    = hd_reg;
    assign match = match_reg;
    assign less  = less_reg;

endmodule

[sv/sukt_group.sv]
`timescale 1ns / 1ps

module sukt_group #(
    parameter int BASE = 0,
    parameter int PW   = 8,
    parameter int HW   = 16
) (
    input  logic                                                aclk,
    input  logic                                                en,
    input  logic [sukt_pkg::GROUP_SIZE-1:0]                     match,
    input  logic [sukt_pkg::GROUP_SIZE-1:0]                     less,
    input  logic                                                less_prev,
    input  logic [sukt_pkg::GROUP_SIZE-1:0][sukt_pkg::PC_W-1:0] pc,
    input  logic [sukt_pkg::GROUP_SIZE-1:0][HW-1:0]             hd,
    output logic                                                hit,
    output logic [PW-1:0]                                       hit_pos,
    output sukt_pkg::postal_t                                   hit_pc,
    output logic [HW-1:0]                                       hit_hd,
    output logic [PW-1:0]                                       bnd_pos
);

    localparam int GS = sukt_pkg::GROUP_SIZE;

    logic [GS-1:0]     less_left;
    logic              hit_c;
    logic [PW-1:0]     hit_pos_c;
    sukt_pkg::postal_t hit_pc_c;
    logic [HW-1:0]     hit_hd_c;
    logic [PW-1:0]     bnd_pos_c;

    logic              hit_reg;
    logic [PW-1:0]     hit_pos_reg;
    sukt_pkg::postal_t hit_pc_reg;
    logic [HW-1:0]     hit_hd_reg;
    logic [PW-1:0]     bnd_pos_reg;

    // Less flag of each cell's left neighbor.
    assign less_left = {less[GS-2:0], less_prev};

    // At most one cell matches and at most one sits on the sorted boundary
    // over the whole row, so plain OR merges the contributions.
    always_comb begin
        hit_c     = 1'b0;
        hit_pos_c = '0;
        hit_pc_c  = '0;
        hit_hd_c  = '0;
        bnd_pos_c = '0;
        for (int k = 0; k < GS; k++) begin
            hit_c     = hit_c | match[k];
            hit_pos_c = hit_pos_c | (match[k] ? PW'(BASE + k) : '0);
            hit_pc_c  = hit_pc_c | (match[k] ? pc[k] : '0);
            hit_hd_c  = hit_hd_c | (match[k] ? hd[k] : '0);
            bnd_pos_c = bnd_pos_c | ((!less[k] && less_left[k]) ? PW'(BASE + k) : '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg     <= hit_c;
            hit_pos_reg <= hit_pos_c;
            hit_pc_reg  <= hit_pc_c;
            hit_hd_reg  <= hit_hd_c;
            bnd_pos_reg <= bnd_pos_c;
        end
    end

    assign hit     = hit_reg;
    assign hit_pos = hit_pos_reg;
    assign hit_pc  = hit_pc_reg;
    assign hit_hd  = hit_hd_reg;
    assign bnd_pos = bnd_pos_reg;

endmodule

[sv/sorted_unique_key_table_unit.sv]
`timescale 1ns / 1ps
// A request is taken only while idle; the row of cells compares, sixteen-cell
// groups reduce, then the result is registered and the row shifts, and only then
// is the next request taken. A stalled result port holds the finish phase.
// Reset clears the fill count and the handshakes; table contents are left
// undefined and are never read before they are written. No clearing pass.
`include "sorted_unique_key_table_unit_macros.svh"

module sorted_unique_key_table_unit #(
    parameter int CAPACITY     = 256,
    parameter int HANDLE_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: opcode[1:0], postal_code[21:2], mail_number[68:22],
    // record_handle[84:69], zero fill[87:85].
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sukt_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: status[1:0], position[9:2], found_postal_code[29:10],
    // found_handle[45:30], entry_count[54:46], zero fill[55].
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sukt_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int GS = sukt_pkg::GROUP_SIZE;
    localparam int NG = (CAPACITY + GS - 1) / GS;
    localparam int NP = NG * GS;
    localparam int HW = HANDLE_WIDTH;
    localparam int PCW = sukt_pkg::PC_W;

    // Sequencer phases.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_CMP  = 2'd1;
    localparam logic [1:0] PH_RED  = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;

    logic [1:0]                       phase_reg, phase_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic [sukt_pkg::OP_W-1:0]        key_op_reg;
    sukt_pkg::postal_t                key_pc_reg;
    sukt_pkg::number_t                key_num_reg;
    logic [HW-1:0]                    key_hd_reg;

    logic                             m_tvalid_reg;
    logic [sukt_pkg::STATUS_W-1:0]    status_reg;
    logic [sukt_pkg::POS_OUT_W-1:0]   pos_reg;
    sukt_pkg::postal_t                fpc_reg;
    logic [sukt_pkg::HANDLE_IN_W-1:0] fh_reg;
    logic [sukt_pkg::COUNT_OUT_W-1:0] cnt_out_reg;

    logic                             s_accept;
    logic                             cmp_en;
    logic                             red_en;
    logic                             commit;
    sukt_pkg::cell_ctrl_t             cell_ctrl;
    logic [PW-1:0]                    upd_pos;

    sukt_pkg::postal_t                cell_pc    [CAPACITY];
    sukt_pkg::number_t                cell_num   [CAPACITY];
    logic [HW-1:0]                    cell_hd    [CAPACITY];
    logic [CAPACITY-1:0]              cell_match;
    logic [CAPACITY-1:0]              cell_less;

    logic [NP-1:0]                    pad_match;
    logic [NP-1:0]                    pad_less;
    logic [NP-1:0][PCW-1:0]           pad_pc;
    logic [NP-1:0][HW-1:0]            pad_hd;

    logic [NG-1:0]                    grp_hit;
    logic [NG-1:0][PW-1:0]            grp_hit_pos;
    logic [NG-1:0][PCW-1:0]           grp_hit_pc;
    logic [NG-1:0][HW-1:0]            grp_hit_hd;
    logic [NG-1:0][PW-1:0]            grp_bnd_pos;

    logic                             any_match;
    logic [PW-1:0]                    match_pos;
    sukt_pkg::postal_t                match_pc;
    logic [HW-1:0]                    match_hd;
    logic [PW-1:0]                    ins_pos;

    logic                             ins_ok;
    logic                             del_ok;
    logic [sukt_pkg::STATUS_W-1:0]    res_status;
    logic [PW-1:0]                    res_pos;
    sukt_pkg::postal_t                res_pc;
    logic [HW-1:0]                    res_hd;

    // One request at a time; the result register frees the input side.
    assign s_tready = (phase_reg == PH_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign cmp_en   = (phase_reg == PH_CMP);
    assign red_en   = (phase_reg == PH_RED);
    assign commit   = (phase_reg == PH_FIN) && (!m_tvalid_reg || m_tready);

    // Sequencer.
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE: if (s_accept) phase_next = PH_CMP;
            PH_CMP:  phase_next = PH_RED;
            PH_RED:  phase_next = PH_FIN;
            PH_FIN:  if (commit) phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    // Request key capture.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            key_op_reg  <= s_tdata[1:0];
            key_pc_reg  <= s_tdata[21:2];
            key_num_reg <= s_tdata[68:22];
            key_hd_reg  <= HW'(s_tdata[84:69]);
        end
    end

    // Row of storage cells with neighbor links.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        sukt_pkg::postal_t lpc, rpc;
        sukt_pkg::number_t lnum, rnum;
        logic [HW-1:0]     lhd, rhd;

        if (i == 0) begin : g_first
            assign lpc  = cell_pc[i];
            assign lnum = cell_num[i];
            assign lhd  = cell_hd[i];
        end else begin : g_inner_l
            assign lpc  = cell_pc[i-1];
            assign lnum = cell_num[i-1];
            assign lhd  = cell_hd[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign rpc  = cell_pc[i];
            assign rnum = cell_num[i];
            assign rhd  = cell_hd[i];
        end else begin : g_inner_r
            assign rpc  = cell_pc[i+1];
            assign rnum = cell_num[i+1];
            assign rhd  = cell_hd[i+1];
        end

        sukt_cell #(
            .CELL_IDX (i),
            .PW       (PW),
            .CW       (CW),
            .HW       (HW)
        ) u_cell (
            .aclk      (aclk),
            .cmp_en    (cmp_en),
            .ctrl      (cell_ctrl),
            .upd_pos   (upd_pos),
            .count     (count_reg),
            .key_pc    (key_pc_reg),
            .key_num   (key_num_reg),
            .key_hd    (key_hd_reg),
            .left_pc   (lpc),
            .left_num  (lnum),
            .left_hd   (lhd),
            .right_pc  (rpc),
            .right_num (rnum),
            .right_hd  (rhd),
            .pc        (cell_pc[i]),
            .num       (cell_num[i]),
            .hd        (cell_hd[i]),
            .match     (cell_match[i]),
            .less      (cell_less[i])
        );
    end

    // Pad the row to whole groups; padding never matches and is never less.
    for (genvar k = 0; k < NP; k++) begin : g_pad
        if (k < CAPACITY) begin : g_real
            assign pad_match[k] = cell_match[k];
            assign pad_less[k]  = cell_less[k];
            assign pad_pc[k]    = cell_pc[k];
            assign pad_hd[k]    = cell_hd[k];
        end else begin : g_fill
            assign pad_match[k] = 1'b0;
            assign pad_less[k]  = 1'b0;
            assign pad_pc[k]    = '0;
            assign pad_hd[k]    = '0;
        end
    end

    // First reduction level, registered per group.
    for (genvar g = 0; g < NG; g++) begin : g_grp
        logic prev_less;

        if (g == 0) begin : g_head
            assign prev_less = 1'b1;
        end else begin : g_tail
            assign prev_less = pad_less[g*GS-1];
        end

        sukt_group #(
            .BASE (g * GS),
            .PW   (PW),
            .HW   (HW)
        ) u_group (
            .aclk      (aclk),
            .en        (red_en),
            .match     (pad_match[g*GS +: GS]),
            .less      (pad_less[g*GS +: GS]),
            .less_prev (prev_less),
            .pc        (pad_pc[g*GS +: GS]),
            .hd        (pad_hd[g*GS +: GS]),
            .hit       (grp_hit[g]),
            .hit_pos   (grp_hit_pos[g]),
            .hit_pc    (grp_hit_pc[g]),
            .hit_hd    (grp_hit_hd[g]),
            .bnd_pos   (grp_bnd_pos[g])
        );
    end

    // Final merge across the groups.
    always_comb begin
        match_pos = '0;
        match_pc  = '0;
        match_hd  = '0;
        ins_pos   = '0;
        for (int g = 0; g < NG; g++) begin
            match_pos = match_pos | grp_hit_pos[g];
            match_pc  = match_pc | grp_hit_pc[g];
            match_hd  = match_hd | grp_hit_hd[g];
            ins_pos   = ins_pos | grp_bnd_pos[g];
        end
    end

    assign any_match = |grp_hit;

    // Outcome of the request.
    always_comb begin
        ins_ok     = 1'b0;
        del_ok     = 1'b0;
        res_status = sukt_pkg::ST_NOT_FOUND;
        res_pos    = '0;
        res_pc     = '0;
        res_hd     = '0;
        unique case (key_op_reg) inside
            sukt_pkg::OP_INSERT: begin
                if (any_match) begin
                    res_status = sukt_pkg::ST_DUPLICATE;
                    res_pos    = match_pos;
                    res_pc     = match_pc;
                    res_hd     = match_hd;
                end else if (count_reg == CW'(CAPACITY)) begin
                    res_status = sukt_pkg::ST_FULL;
                end else begin
                    ins_ok     = 1'b1;
                    res_status = sukt_pkg::ST_OK;
                    res_pos    = ins_pos;
                end
            end
            sukt_pkg::OP_DELETE, sukt_pkg::OP_FIND: begin
                if (any_match) begin
                    del_ok     = (key_op_reg == sukt_pkg::OP_DELETE);
                    res_status = sukt_pkg::ST_OK;
                    res_pos    = match_pos;
                    res_pc     = match_pc;
                    res_hd     = match_hd;
                end
            end
            default: begin
                res_status = sukt_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    // Row update command, applied in the commit cycle.
    assign cell_ctrl.ins_en = commit && ins_ok;
    assign cell_ctrl.del_en = commit && del_ok;
    assign upd_pos          = ins_ok ? ins_pos : match_pos;

    always_comb begin
        count_next = count_reg;
        if (commit && ins_ok) begin
            count_next = count_reg + CW'(1);
        end else if (commit && del_ok) begin
            count_next = count_reg - CW'(1);
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            if (commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (commit) begin
            status_reg  <= res_status;
            pos_reg     <= sukt_pkg::POS_OUT_W'(res_pos);
            fpc_reg     <= res_pc;
            fh_reg      <= sukt_pkg::HANDLE_IN_W'(res_hd);
            cnt_out_reg <= sukt_pkg::COUNT_OUT_W'(count_next);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, cnt_out_reg, fh_reg, fpc_reg, pos_reg, status_reg};

    // Checks.
    `SUKT_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(CAPACITY), "fill count beyond capacity")
    `SUKT_ASSERT_IMPL(a_unique_hit, phase_reg == PH_FIN, $onehot0(grp_hit), "key matched twice")
    `SUKT_ASSERT_NEXT(a_delete_count, commit && del_ok, count_reg == $past(count_reg) - CW'(1), "delete did not shrink table")

endmodule

[test/sorted_unique_key_table_unit_checker.sv]
`timescale 1ns / 1ps

module sorted_unique_key_table_unit_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // s_tdata: opcode, postal_code, mail_number, record_handle, zero fill.
    input  logic [sukt_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: status, position, found_postal_code, found_handle, entry_count, zero fill.
    input  logic [sukt_pkg::M_TDATA_W-1:0] m_tdata,
    output int                             mismatch_count,
    output int                             pending_results
);

    localparam int TABLE_DEPTH = 256;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [sukt_pkg::STATUS_W-1:0]    status;
        logic [sukt_pkg::POS_OUT_W-1:0]   position;
        sukt_pkg::postal_t                postal_code;
        logic [sukt_pkg::HANDLE_IN_W-1:0] handle;
        logic [sukt_pkg::COUNT_OUT_W-1:0] entry_count;
    } lookup_result_t;

    // Shadow copy of the sorted table.
    sukt_pkg::postal_t                shadow_postal [TABLE_DEPTH];
    sukt_pkg::number_t                shadow_number [TABLE_DEPTH];
    logic [sukt_pkg::HANDLE_IN_W-1:0] shadow_handle [TABLE_DEPTH];
    int                               shadow_fill;

    // Results still owed by the block, oldest first.
    lookup_result_t expected_results [$];

    // Returns the slot holding the number, or the fill count if it is absent.
    function automatic int find_slot(sukt_pkg::number_t num);
        int k;
        for (k = 0; k < shadow_fill; k++) begin
            if (shadow_number[k] == num) begin
                return k;
            end
        end
        return shadow_fill;
    endfunction

    // Applies one request to the shadow table and returns the result it causes.
    function automatic lookup_result_t apply_request(logic [sukt_pkg::OP_W-1:0] op,
                                                     sukt_pkg::postal_t pc,
                                                     sukt_pkg::number_t num,
                                                     logic [sukt_pkg::HANDLE_IN_W-1:0] hd);
        lookup_result_t r;
        int slot;
        int k;
        r = '0;
        r.status = sukt_pkg::ST_NOT_FOUND;
        slot = find_slot(num);
        if (op == sukt_pkg::OP_INSERT) begin
            if (slot < shadow_fill) begin
                // The number is already present: report the existing entry.
                r.status      = sukt_pkg::ST_DUPLICATE;
                r.position    = sukt_pkg::POS_OUT_W'(slot);
                r.postal_code = shadow_postal[slot];
                r.handle      = shadow_handle[slot];
            end else if (shadow_fill >= TABLE_DEPTH) begin
                r.status = sukt_pkg::ST_FULL;
            end else begin
                // Find the sorted slot, then open a gap for the new entry.
                slot = 0;
                while (slot < shadow_fill && (shadow_postal[slot] < pc ||
                       (shadow_postal[slot] == pc && shadow_number[slot] < num))) begin
                    slot++;
                end
                for (k = shadow_fill; k > slot; k--) begin
                    shadow_postal[k] = shadow_postal[k-1];
                    shadow_number[k] = shadow_number[k-1];
                    shadow_handle[k] = shadow_handle[k-1];
                end
                shadow_postal[slot] = pc;
                shadow_number[slot] = num;
                shadow_handle[slot] = hd;
                shadow_fill++;
                r.status   = sukt_pkg::ST_OK;
                r.position = sukt_pkg::POS_OUT_W'(slot);
            end
        end else if ((op == sukt_pkg::OP_DELETE || op == sukt_pkg::OP_FIND) &&
                     slot < shadow_fill) begin
            r.status      = sukt_pkg::ST_OK;
            r.position    = sukt_pkg::POS_OUT_W'(slot);
            r.postal_code = shadow_postal[slot];
            r.handle      = shadow_handle[slot];
            if (op == sukt_pkg::OP_DELETE) begin
                // Close the gap left by the removed entry.
                for (k = slot; k + 1 < shadow_fill; k++) begin
                    shadow_postal[k] = shadow_postal[k+1];
                    shadow_number[k] = shadow_number[k+1];
                    shadow_handle[k] = shadow_handle[k+1];
                end
                shadow_fill--;
            end
        end
        r.entry_count = sukt_pkg::COUNT_OUT_W'(shadow_fill);
        return r;
    endfunction

    // Compare each result with the oldest owed one, then predict for a new request.
    always @(posedge aclk) begin : monitor
        lookup_result_t got;
        lookup_result_t want;
        if (!aresetn) begin
            shadow_fill = 0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.status      = m_tdata[1:0];
                got.position    = m_tdata[9:2];
                got.postal_code = m_tdata[29:10];
                got.handle      = m_tdata[45:30];
                got.entry_count = m_tdata[54:46];
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: result with no request pending: status %0d pos %0d",
                                 $realtime, got.status, got.position);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.position !== want.position ||
                        got.postal_code !== want.postal_code || got.handle !== want.handle ||
                        got.entry_count !== want.entry_count) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("%0t: mismatch: expected status %0d pos %0d postal %0d",
                                     $realtime, want.status, want.position,
                                     want.postal_code,
                                     " handle %0d count %0d,", want.handle,
                                     want.entry_count,
                                     " got status %0d pos %0d postal %0d", got.status,
                                     got.position, got.postal_code,
                                     " handle %0d count %0d", got.handle,
                                     got.entry_count);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_request(s_tdata[1:0], s_tdata[21:2],
                                                         s_tdata[68:22], s_tdata[84:69]));
            end
        end
        pending_results = expected_results.size();
    end

endmodule

[test/sorted_unique_key_table_unit_test.sv]
`timescale 1ns / 1ps

module sorted_unique_key_table_unit_test;

    localparam int TABLE_DEPTH  = 256;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PERCENT = 9;

    // The one opcode value that the block ignores.
    localparam logic [sukt_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [sukt_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [sukt_pkg::M_TDATA_W-1:0] m_tdata;

    int mismatch_count;
    int pending_results;

    // Steady and hold_requests are shared between the sender and the receiver.
    bit steady        = 1'b0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    // Numbers the table should hold, used to aim deletes, finds and duplicates.
    sukt_pkg::number_t live_numbers [$];

    always #4 aclk = ~aclk;

    sorted_unique_key_table_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sorted_unique_key_table_unit_checker table_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    function automatic int live_index(sukt_pkg::number_t num);
        int k;
        for (k = 0; k < live_numbers.size(); k++) begin
            if (live_numbers[k] == num) begin
                return k;
            end
        end
        return -1;
    endfunction

    // Small numbers collide often; the rest spread over the full width.
    function automatic sukt_pkg::number_t random_number();
        int roll;
        logic [63:0] wide;
        roll = $urandom_range(0, 99);
        wide = {$urandom, $urandom};
        if (roll < 30) begin
            return sukt_pkg::number_t'($urandom_range(0, 31));
        end else if (roll < 35) begin
            return '1;
        end
        return wide[sukt_pkg::NUM_W-1:0];
    endfunction

    // A few postal codes are reused so that ties fall back on the number.
    function automatic sukt_pkg::postal_t random_postal();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            return sukt_pkg::postal_t'($urandom_range(0, 7));
        end else if (roll < 50) begin
            return sukt_pkg::postal_t'(999999);
        end else if (roll < 60) begin
            return '1;
        end
        return sukt_pkg::postal_t'($urandom);
    endfunction

    function automatic sukt_pkg::number_t pick_number(int reuse_percent);
        if (live_numbers.size() > 0 && $urandom_range(0, 99) < reuse_percent) begin
            return live_numbers[$urandom_range(0, live_numbers.size() - 1)];
        end
        return random_number();
    endfunction

    // Offer one request and hold it until the block takes it.
    task automatic offer_request(logic [sukt_pkg::OP_W-1:0] op, sukt_pkg::postal_t pc,
                                 sukt_pkg::number_t num,
                                 logic [sukt_pkg::HANDLE_IN_W-1:0] hd);
        int idx;
        if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tdata  <= {3'b000, hd, num, pc, op};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        idx = live_index(num);
        if (op == sukt_pkg::OP_INSERT && idx < 0 && live_numbers.size() < TABLE_DEPTH) begin
            live_numbers.push_back(num);
        end else if (op == sukt_pkg::OP_DELETE && idx >= 0) begin
            live_numbers.delete(idx);
        end
    endtask

    // Run a stretch of random requests with the given opcode mix in percent.
    task automatic run_phase(int items, int insert_pct, int delete_pct, int find_pct);
        int roll;
        logic [sukt_pkg::OP_W-1:0] op;
        sukt_pkg::number_t num;
        repeat (items) begin
            roll = $urandom_range(0, 99);
            if (roll < insert_pct) begin
                op  = sukt_pkg::OP_INSERT;
                num = pick_number(15);
            end else if (roll < insert_pct + delete_pct) begin
                op  = sukt_pkg::OP_DELETE;
                num = pick_number(75);
            end else if (roll < insert_pct + delete_pct + find_pct) begin
                op  = sukt_pkg::OP_FIND;
                num = pick_number(75);
            end else begin
                op  = OP_RESERVED;
                num = random_number();
            end
            offer_request(op, random_postal(), num, sukt_pkg::HANDLE_IN_W'($urandom));
        end
    endtask

    // Result side: random stalls, or a long hold-off when the sender asks for one.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES - 1;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Give up when neither channel moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("sorted_unique_key_table_unit test failed");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests: empty table, opcode extremes, ties, duplicates.
        offer_request(sukt_pkg::OP_FIND, '0, '0, '0);
        offer_request(sukt_pkg::OP_DELETE, '0, '0, '0);
        offer_request(OP_RESERVED, '0, '0, '0);
        offer_request(sukt_pkg::OP_INSERT, '0, '0, '0);
        offer_request(sukt_pkg::OP_INSERT, '1, '1, '1);
        offer_request(sukt_pkg::OP_INSERT, sukt_pkg::postal_t'(999999),
                      sukt_pkg::number_t'(47'd99999999999999), 16'h1234);
        offer_request(sukt_pkg::OP_INSERT, sukt_pkg::postal_t'(999999), '0, 16'hBEEF);
        offer_request(sukt_pkg::OP_INSERT, '0, sukt_pkg::number_t'(5), 16'h0005);
        offer_request(sukt_pkg::OP_INSERT, '0, sukt_pkg::number_t'(3), 16'h0003);
        offer_request(sukt_pkg::OP_FIND, sukt_pkg::postal_t'(17), '1, '0);
        offer_request(sukt_pkg::OP_FIND, '0, sukt_pkg::number_t'(5), '0);
        offer_request(sukt_pkg::OP_DELETE, '0, sukt_pkg::number_t'(3), '0);
        offer_request(sukt_pkg::OP_DELETE, '0, sukt_pkg::number_t'(3), '0);
        offer_request(OP_RESERVED, '1, '1, '1);
        offer_request(sukt_pkg::OP_DELETE, '0, '0, '0);
        offer_request(sukt_pkg::OP_FIND, '0, '0, '0);

        // Fill past capacity while the result side holds off at first.
        hold_requests <= hold_requests + 1;
        run_phase(400, 88, 5, 5);
        run_phase(500, 40, 28, 28);

        // A stretch where neither side idles.
        steady <= 1'b1;
        run_phase(300, 45, 26, 26);
        steady <= 1'b0;

        // Drain toward empty, then fill again under a second hold-off.
        run_phase(350, 10, 75, 13);
        hold_requests <= hold_requests + 1;
        run_phase(200, 85, 5, 8);
        s_tvalid <= 1'b0;

        // Let the checker log the last request before waiting for its result.
        @(posedge aclk);
        wait (pending_results == 0);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("sorted_unique_key_table_unit test passed");
        end else begin
            $display("sorted_unique_key_table_unit test failed");
        end
        $finish;
    end

endmodule
